### rtl/wgm_pkg.sv
// Shared types, constants and helper functions for the wildcard glob matcher.
// Used by wildcard_glob_matcher_core and the testbench; depends on nothing else.

package wgm_pkg;

	// Longest pattern that can be stored, in bytes.
	localparam int PAT_LEN = 32;
	// Number of pattern positions, from zero up to and including PAT_LEN.
	localparam int POS_W = PAT_LEN + 1;
	// Width of the pattern length and of an index into the position vector.
	localparam int LEN_W = $clog2(PAT_LEN + 1);
	// Width of an index into the pattern store.
	localparam int IDX_W = (PAT_LEN > 1) ? $clog2(PAT_LEN) : 1;

	localparam logic [7:0] STAR_BYTE = 8'h2A;
	localparam logic [7:0] ANY_BYTE = 8'h3F;
	localparam logic [7:0] LOWER_A = 8'h61;
	localparam logic [7:0] LOWER_Z = 8'h7A;
	localparam logic [7:0] CASE_OFFSET = 8'h20;

	// Request commands.
	typedef enum logic [1:0] {
		CMD_CLEAR = 2'd0,
		CMD_APPEND = 2'd1,
		CMD_TEXT = 2'd2,
		CMD_END = 2'd3
	} cmd_t;

	typedef logic [POS_W-1:0] pos_vec_t;
	typedef logic [PAT_LEN-1:0] pat_vec_t;

	// Fold lower-case ASCII letters to upper case; all other bytes pass unchanged.
	function automatic logic [7:0] fold_upper(input logic [7:0] c);
		logic [7:0] r;
		r = c;
		if (c >= LOWER_A && c <= LOWER_Z) begin
			r = c - CASE_OFFSET;
		end
		return r;
	endfunction

	// Close an active vector over star runs: an active star position also
	// activates the next one. This is a carry chain, computed as a
	// log-depth parallel prefix so that only a few gate levels stand in the path.
	function automatic pos_vec_t star_close(input pos_vec_t act, input pat_vec_t star);
		pos_vec_t g;
		pos_vec_t p;
		pos_vec_t g_prev;
		pos_vec_t p_prev;
		g = act;
		p = {star, 1'b0};
		for (int d = 1; d < POS_W; d = d * 2) begin
			g_prev = g;
			p_prev = p;
			for (int k = d; k < POS_W; k++) begin
				g[k] = g_prev[k] | (p_prev[k] & g_prev[k-d]);
				p[k] = p_prev[k] & p_prev[k-d];
			end
		end
		return g;
	endfunction

endpackage

### rtl/wildcard_glob_matcher_core.sv
// Top level of the streaming, case-insensitive wildcard glob matcher.
// Depends on wgm_pkg for the command codes, sizes and the star-closure function.
//
// Usage: requests arrive on the input channel (in_valid, in_ready, cmd, ch).
// A clear request empties the pattern, append requests add one pattern byte
// each, text requests stream one text byte each, and an end request closes
// the text. Only the end request produces a result on the output channel
// (out_valid, out_ready, matched, overflow); every other request produces none.
// '?' matches one byte, '*' matches any run, and letters compare without case.
// Clear, append and end all rearm the matcher for a new text.
// A request is held in the input register from the edge that accepts it; an
// end request's result moves on into the output register once that register is free.
// Throughput: one request per cycle, unless an end request waits for the
// output register. The whole pattern is evaluated in parallel as one bit
// vector of active positions per cycle.
// Reset empties the pattern, clears the overflow flag and rearms the matcher.
// When the receiver stalls, the held result waits in the output register;
// clear, append and text requests keep flowing, and only an end request
// waits in the input register until the output register is free.

module wildcard_glob_matcher_core
	import wgm_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	input logic [1:0] cmd,
	input logic [7:0] ch,
	output logic out_valid,
	input logic out_ready,
	output logic matched,
	output logic overflow
);

	// Input register.
	logic valid_s1;
	logic [1:0] cmd_s1;
	logic [7:0] ch_s1;

	// Result register.
	logic out_valid_s2;
	logic matched_s2;
	logic overflow_s2;

	// Matcher state.
	logic [7:0] pat_q [PAT_LEN];
	logic [LEN_W-1:0] len_q;
	pos_vec_t act_q;
	logic ovf_q;

	// Combinational signals.
	cmd_t cmd_e;
	logic out_free;
	logic adv;
	logic full;
	logic [7:0] ch_up;
	pat_vec_t live;
	pat_vec_t star;
	pat_vec_t hit;
	pat_vec_t wr_sel;
	pat_vec_t star_rearm;
	pos_vec_t step_vec;
	pos_vec_t text_vec;
	pos_vec_t rearm_vec;
	logic end_hit;

	// Handshake: the input register drains unless an end request must wait
	// for the output register.
	assign cmd_e = cmd_t'(cmd_s1);
	assign out_free = !out_valid_s2 || out_ready;
	assign adv = valid_s1 && (cmd_e != CMD_END || out_free);
	assign in_ready = !valid_s1 || adv;

	assign out_valid = out_valid_s2;
	assign matched = matched_s2;
	assign overflow = overflow_s2;

	// Per-position decode of the stored pattern against the held byte.
	always_comb begin
		full = (len_q == LEN_W'(PAT_LEN));
		ch_up = fold_upper(ch_s1);
		for (int i = 0; i < PAT_LEN; i++) begin
			live[i] = (LEN_W'(i) < len_q);
			wr_sel[i] = (LEN_W'(i) == len_q);
			star[i] = live[i] && (pat_q[i] == STAR_BYTE);
			hit[i] = live[i] && !star[i] && (pat_q[i] == ANY_BYTE || pat_q[i] == ch_up);
		end
	end

	// One text byte: stars hold their position, matching bytes advance.
	always_comb begin
		step_vec = '0;
		for (int i = 0; i < PAT_LEN; i++) begin
			step_vec[i] = step_vec[i] | (act_q[i] & star[i]);
			step_vec[i+1] = act_q[i] & hit[i];
		end
		text_vec = star_close(step_vec, star);
	end

	// Rearm vector, taken over the pattern as it stands after this request.
	always_comb begin
		unique case (cmd_e)
			CMD_CLEAR: star_rearm = '0;
			CMD_APPEND: begin
				star_rearm = star;
				if (!full && fold_upper(ch_s1) == STAR_BYTE) begin
					star_rearm = star | wr_sel;
				end
			end
			CMD_TEXT, CMD_END: star_rearm = star;
			default: star_rearm = star;
		endcase
		rearm_vec = star_close(POS_W'(1), star_rearm);
		end_hit = !ovf_q && act_q[len_q];
	end

	// Input register and matcher control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			out_valid_s2 <= 1'b0;
			len_q <= '0;
			act_q <= POS_W'(1);
			ovf_q <= 1'b0;
		end else begin
			if (in_ready) begin
				valid_s1 <= in_valid;
			end
			if (adv && cmd_e == CMD_END) begin
				out_valid_s2 <= 1'b1;
			end else if (out_ready) begin
				out_valid_s2 <= 1'b0;
			end
			if (adv) begin
				act_q <= (cmd_e == CMD_TEXT) ? text_vec : rearm_vec;
				unique case (cmd_e)
					CMD_CLEAR: begin
						len_q <= '0;
						ovf_q <= 1'b0;
					end
					CMD_APPEND: begin
						if (full) begin
							ovf_q <= 1'b1;
						end else begin
							len_q <= len_q + LEN_W'(1);
						end
					end
					CMD_TEXT, CMD_END: begin
					end
					default: begin
					end
				endcase
			end
		end
	end

	// Payload registers: request bytes, result fields and the pattern store.
	// The store keeps bytes already folded to upper case.
	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			cmd_s1 <= cmd;
			ch_s1 <= ch;
		end
		if (adv && cmd_e == CMD_END) begin
			matched_s2 <= end_hit;
			overflow_s2 <= ovf_q;
		end
		if (adv && cmd_e == CMD_APPEND && !full) begin
			pat_q[len_q[IDX_W-1:0]] <= fold_upper(ch_s1);
		end
	end

	// A match is never reported together with an overflow.
	a_no_match_on_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_s2 |-> !(matched_s2 && overflow_s2))
		else $error("match reported with pattern overflow");

	// The overflow flag is only set once the store is full.
	a_overflow_full: assert property (@(posedge clk) disable iff (!arst_n)
		ovf_q |-> (len_q == LEN_W'(PAT_LEN)))
		else $error("overflow flag set with room left in the pattern");

	// No position beyond the pattern end is ever active.
	a_act_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(len_q != LEN_W'(PAT_LEN)) |-> ((act_q >> (len_q + LEN_W'(1))) == '0))
		else $error("active position beyond pattern end");

	// Every request other than a text byte leaves position zero active.
	a_rearm: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && cmd_e != CMD_TEXT) |=> act_q[0])
		else $error("rearm did not activate position zero");

endmodule

### test/testbench.sv
// Self-checking testbench for the streaming wildcard glob matcher core.
// Depends on wgm_pkg for the command codes, sizes and special pattern bytes.
// An internal predictor follows every accepted request, and each result is checked against it.

module testbench;
	import wgm_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	typedef logic [7:0] byte_q_t[$];

	// One result of an end request.
	typedef struct packed {
		logic matched;
		logic overflow;
	} verdict_t;

	localparam logic [7:0] UPPER_A = 8'h41;
	localparam logic [7:0] UPPER_Z = 8'h5A;
	localparam int CYCLE_LIMIT = 400000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	cmd_t req_cmd = CMD_CLEAR;
	logic [7:0] req_ch = 8'h00;
	logic out_valid;
	logic out_ready = 1'b0;
	logic matched;
	logic overflow;

	// Predicted state of the matcher.
	logic [7:0] pat_bytes [PAT_LEN];
	int pat_count;
	pos_vec_t live_pos;
	logic pat_overflowed;

	verdict_t expected_verdicts[$];
	byte_q_t cur_pattern;
	int mismatches = 0;
	int items_sent = 0;
	int cycle_count = 0;
	int send_idle_pct = 8;
	int recv_idle_pct = 86;

	wildcard_glob_matcher_core uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.cmd(req_cmd),
		.ch(req_ch),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.matched(matched),
		.overflow(overflow)
	);

	always #4 clk = ~clk;

	// Only lower-case letters are folded; every other byte compares as it is.
	function automatic logic [7:0] upcase(input logic [7:0] c);
		if (c >= LOWER_A && c <= LOWER_Z) begin
			return c - CASE_OFFSET;
		end
		return c;
	endfunction

	// An active star position also activates the position after it.
	// Walking upward lets a run of stars propagate in one pass.
	function automatic void spread_over_stars();
		for (int i = 0; i < pat_count; i++) begin
			if (live_pos[i] && pat_bytes[i] == STAR_BYTE) begin
				live_pos[i+1] = 1'b1;
			end
		end
	endfunction

	function automatic void restart_text();
		live_pos = '0;
		live_pos[0] = 1'b1;
		spread_over_stars();
	endfunction

	// Advance the predicted state by one accepted request.
	function automatic void predict_request(input cmd_t c, input logic [7:0] b);
		pos_vec_t nxt;
		verdict_t v;
		case (c)
			CMD_CLEAR: begin
				pat_count = 0;
				pat_overflowed = 1'b0;
				restart_text();
			end
			CMD_APPEND: begin
				if (pat_count < PAT_LEN) begin
					pat_bytes[pat_count] = b;
					pat_count++;
				end else begin
					pat_overflowed = 1'b1;
				end
				restart_text();
			end
			CMD_TEXT: begin
				nxt = '0;
				for (int i = 0; i < pat_count; i++) begin
					if (live_pos[i]) begin
						if (pat_bytes[i] == STAR_BYTE) begin
							nxt[i] = 1'b1;
						end else if (pat_bytes[i] == ANY_BYTE || upcase(pat_bytes[i]) == upcase(b)) begin
							nxt[i+1] = 1'b1;
						end
					end
				end
				live_pos = nxt;
				spread_over_stars();
			end
			default: begin
				v.matched = !pat_overflowed && live_pos[pat_count];
				v.overflow = pat_overflowed;
				expected_verdicts.push_back(v);
				restart_text();
			end
		endcase
	endfunction

	function automatic logic [7:0] any_byte_value();
		return 8'($urandom_range(0, 255));
	endfunction

	// Pattern and text content drawn mostly from a small alphabet so that
	// matches are common, with stars, wildcards and extreme bytes mixed in.
	function automatic logic [7:0] random_pat_byte();
		int unsigned r;
		logic [7:0] b;
		r = $urandom_range(0, 99);
		if (r < 40) begin
			b = UPPER_A + 8'($urandom_range(0, 1));
			if ($urandom_range(0, 1)) begin
				b = b | CASE_OFFSET;
			end
			return b;
		end else if (r < 55) begin
			return STAR_BYTE;
		end else if (r < 70) begin
			return ANY_BYTE;
		end else if (r < 80) begin
			return $urandom_range(0, 1) ? 8'h00 : 8'hFF;
		end
		return any_byte_value();
	endfunction

	// Build a text that the pattern would accept, then damage it now and then.
	function automatic byte_q_t text_for(input byte_q_t pat);
		byte_q_t t;
		int idx;
		logic [7:0] p;
		t = {};
		foreach (pat[i]) begin
			p = pat[i];
			if (p == STAR_BYTE) begin
				repeat ($urandom_range(0, 3)) t.push_back(random_pat_byte());
			end else if (p == ANY_BYTE) begin
				t.push_back(any_byte_value());
			end else if ((p >= UPPER_A && p <= UPPER_Z) || (p >= LOWER_A && p <= LOWER_Z)) begin
				t.push_back($urandom_range(0, 1) ? (p ^ CASE_OFFSET) : p);
			end else begin
				t.push_back(p);
			end
		end
		if ($urandom_range(0, 99) < 30) begin
			idx = $urandom_range(0, t.size());
			case ($urandom_range(0, 2))
				0: t.insert(idx, random_pat_byte());
				1: if (idx < t.size()) t.delete(idx);
				default: if (idx < t.size()) t[idx] = random_pat_byte();
			endcase
		end
		return t;
	endfunction

	// Send one request. Entered and left just after a falling edge; valid
	// stays high on exit so back-to-back requests follow without a gap.
	task automatic send_req(input cmd_t c, input logic [7:0] b);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		req_cmd <= c;
		req_ch <= b;
		do begin
			@(posedge clk);
		end while (!in_ready);
		predict_request(c, b);
		items_sent++;
		@(negedge clk);
	endtask

	task automatic send_pattern(input byte_q_t p, input bit do_clear);
		if (do_clear) begin
			send_req(CMD_CLEAR, any_byte_value());
			cur_pattern = {};
		end
		foreach (p[i]) begin
			send_req(CMD_APPEND, p[i]);
			cur_pattern.push_back(p[i]);
		end
	endtask

	task automatic send_text(input byte_q_t t);
		foreach (t[i]) begin
			send_req(CMD_TEXT, t[i]);
		end
		send_req(CMD_END, any_byte_value());
	endtask

	// Empty pattern right after reset: only the empty text matches.
	task automatic test_empty_pattern();
		send_req(CMD_END, 8'hFF);
		send_req(CMD_TEXT, 8'h61);
		send_req(CMD_END, 8'h00);
	endtask

	// Letters compare without case; brackets and braces are not folded.
	task automatic test_case_folding();
		send_pattern('{8'h61, 8'h7B}, 1'b1);
		send_text('{8'h41, 8'h5B});
		send_text('{8'h41, 8'h7B});
	endtask

	// A star may match nothing, a wildcard needs exactly one byte, and an
	// all-star pattern matches the empty text.
	task automatic test_wildcards();
		byte_q_t none;
		none = {};
		send_pattern('{STAR_BYTE, ANY_BYTE}, 1'b1);
		send_text(none);
		send_text('{8'hFF});
		send_pattern('{STAR_BYTE}, 1'b1);
		send_text(none);
	endtask

	// The zero byte is an ordinary character on both sides.
	task automatic test_zero_byte();
		send_pattern('{8'h00}, 1'b1);
		send_text('{8'h00});
	endtask

	// An append in the middle of a text restarts that text.
	task automatic test_append_mid_text();
		send_req(CMD_TEXT, 8'h00);
		send_pattern('{STAR_BYTE}, 1'b0);
		send_text('{8'h00});
	endtask

	// A full pattern refuses further appends; the flag holds until a clear.
	task automatic test_pattern_overflow();
		byte_q_t p;
		byte_q_t none;
		p = {};
		none = {};
		repeat (PAT_LEN) p.push_back(random_pat_byte());
		send_pattern(p, 1'b1);
		repeat ($urandom_range(1, 3)) send_req(CMD_APPEND, any_byte_value());
		send_text(text_for(p));
		send_text(text_for(p));
		send_req(CMD_CLEAR, any_byte_value());
		cur_pattern = {};
		send_text(none);
	endtask

	// Mostly well-formed pattern and text sequences with random content,
	// plus raw requests of any command and the odd overflowing pattern.
	task automatic test_random_sequences(input int n_items);
		int stop_at;
		int unsigned r;
		byte_q_t p;
		stop_at = items_sent + n_items;
		while (items_sent < stop_at) begin
			r = $urandom_range(0, 99);
			if (r < 8) begin
				repeat ($urandom_range(1, 4)) send_req(cmd_t'($urandom_range(0, 3)), any_byte_value());
			end else if (r < 12) begin
				test_pattern_overflow();
			end else begin
				p = {};
				repeat (($urandom_range(0, 99) < 80) ? $urandom_range(0, 8) : $urandom_range(9, PAT_LEN))
					p.push_back(random_pat_byte());
				send_pattern(p, $urandom_range(0, 99) < 85);
				repeat ($urandom_range(1, 4)) send_text(text_for(cur_pattern));
			end
		end
	endtask

	// Receiver stalls at random.
	always @(negedge clk) begin
		out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
	end

	// Compare each accepted result with the oldest prediction.
	always @(posedge clk) begin
		verdict_t want;
		if (arst_n && out_valid && out_ready) begin
			if (expected_verdicts.size() == 0) begin
				$display("%0t: unexpected result, matched %0b overflow %0b", $time, matched, overflow);
				mismatches++;
			end else begin
				want = expected_verdicts.pop_front();
				if (matched !== want.matched) begin
					$display("%0t: matched mismatch, expected %0b, got %0b", $time, want.matched, matched);
					mismatches++;
				end
				if (overflow !== want.overflow) begin
					$display("%0t: overflow mismatch, expected %0b, got %0b", $time, want.overflow,
						overflow);
					mismatches++;
				end
			end
		end
	end

	// Watchdog against a hung handshake.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	initial begin
		pat_count = 0;
		pat_overflowed = 1'b0;
		restart_text();
		cur_pattern = {};
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		test_empty_pattern();
		test_case_folding();
		test_wildcards();
		test_zero_byte();
		test_append_mid_text();

		// Sender rarely idle, receiver mostly stalled.
		test_pattern_overflow();
		test_random_sequences(160);
		// Sender mostly idle, receiver rarely stalled.
		send_idle_pct = 86;
		recv_idle_pct = 8;
		test_pattern_overflow();
		test_random_sequences(160);
		// Full rate on both sides.
		send_idle_pct = 0;
		recv_idle_pct = 0;
		test_pattern_overflow();
		test_random_sequences(160);

		in_valid <= 1'b0;
		while (expected_verdicts.size() != 0) @(posedge clk);
		repeat (6) @(posedge clk);
		if (mismatches == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

endmodule
